// ===== rtl/atl_pkg.sv =====
// ----------------------------------------------------------------------------
// atl_pkg
// Shared types, codes and character helpers for the assembly token lexer.
// ----------------------------------------------------------------------------
package atl_pkg;

	typedef enum logic [2:0] {
		CLS_INSTR   = 3'd0,
		CLS_REG     = 3'd1,
		CLS_MEM     = 3'd2,
		CLS_IMM     = 3'd3,
		CLS_LABEL   = 3'd4,
		CLS_UNKNOWN = 3'd5
	} tok_class_t;

	typedef struct packed {
		tok_class_t cls;
		logic       start;
		logic       ovf;
	} job_ctl_t;

	localparam int JOB_CTL_W = $bits(job_ctl_t);

	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_R     = 8'h52;
	localparam logic [7:0] CH_M     = 8'h4D;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_B     = 8'h42;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_F     = 8'h46;

	localparam int NUM_MNEM = 11;

	// first character in the top byte, unused tail bytes zero
	localparam logic [31:0] MNEM_TEXT [NUM_MNEM] = '{
		32'h4D4F5600, 32'h41444400, 32'h53554200, 32'h4D554C00,
		32'h44495600, 32'h414E4400, 32'h4F520000, 32'h4A5A0000,
		32'h434D5000, 32'h4C455353, 32'h4E4F5000
	};
	localparam logic [2:0] MNEM_LEN [NUM_MNEM] = '{
		3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd2, 3'd2, 3'd3, 3'd4, 3'd3
	};

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
			(c >= 8'h41 && c <= 8'h46);
	endfunction

	function automatic logic is_delim(input logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D) || c == 8'h2C;
	endfunction

	// tok: first four characters, tok[0] first; n: token length (0 if over 4)
	function automatic logic mnem_match(input logic [3:0][7:0] tok, input logic [2:0] n);
		logic hit;
		logic eq;
		hit = 1'b0;
		for (int i = 0; i < NUM_MNEM; i++) begin
			eq = (MNEM_LEN[i] == n);
			for (int k = 0; k < 4; k++) begin
				if (3'(k) < MNEM_LEN[i] && tok[k] != MNEM_TEXT[i][31-8*k -: 8])
					eq = 1'b0;
			end
			if (eq)
				hit = 1'b1;
		end
		return hit;
	endfunction

endpackage

// ===== rtl/atl_fifo.sv =====
// ----------------------------------------------------------------------------
// atl_fifo
// Two-entry job queue between the lexer front and the emitter.
// ----------------------------------------------------------------------------
module atl_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic         not_empty,
	output logic [W-1:0] rdata
);
	logic [W-1:0] mem_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   cnt_q;

	always_ff @(posedge clk) begin
		if (push && !full)
			mem_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push && !full)
				wr_ptr_q <= !wr_ptr_q;
			if (pop && not_empty)
				rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + 2'(push && !full) - 2'(pop && not_empty);
		end
	end

	assign full      = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign rdata     = mem_q[rd_ptr_q];

endmodule

// ===== rtl/atl_front.sv =====
// ----------------------------------------------------------------------------
// atl_front
// Takes source words, tracks comments, gathers token characters and
// classifies a token when a delimiter closes it; on overflow it halts.
// ----------------------------------------------------------------------------
module atl_front #(
	parameter int StoreDepth = 15,
	parameter int CW = 4
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [7:0]               char_in,
	output logic                     job_push,
	input  logic                     job_full,
	output atl_pkg::job_ctl_t        job_ctl,
	output logic [CW-1:0]            job_count,
	output logic [StoreDepth*8-1:0]  job_data
);
	import atl_pkg::*;

	logic [StoreDepth-1:0][7:0] store_q;
	logic [CW-1:0]              count_q;
	logic [7:0]                 last_char_q;
	logic                       in_comment_q;
	logic                       halted_q;

	logic            act, proceed, delim_c, close_tok, ovf, wr;
	logic [3:0][7:0] tok4;
	logic [6:0]      cnt7;
	logic [2:0]      n3;
	logic [7:0]      c0, c1;
	tok_class_t      cls;
	logic            start;

	assign in_ready = !job_full;

	for (genvar k = 0; k < 4; k++) begin : g_tok4
		if (k < StoreDepth) begin : g_have
			assign tok4[k] = store_q[k];
		end else begin : g_none
			assign tok4[k] = 8'h00;
		end
	end

	always_comb begin
		cnt7 = 7'(count_q);
		n3   = (cnt7 <= 7'd4) ? cnt7[2:0] : 3'd0;
		c0   = store_q[0];
		c1   = (cnt7 > 7'd1) ? store_q[1] : 8'h00;
		start = 1'b0;
		if (last_char_q == CH_COLON) begin
			cls = CLS_LABEL;
		end else if (mnem_match(tok4, n3)) begin
			cls = CLS_INSTR;
		end else if (c0 == CH_HASH || is_hex(c0) || c0 == CH_MINUS) begin
			cls   = CLS_IMM;
			start = (c0 == CH_HASH);
		end else if ((c0 == CH_R && cnt7 > 7'd1 && is_hex(c1)) ||
			(cnt7 == 7'd1 && (c0 == CH_A || c0 == CH_B))) begin
			cls = CLS_REG;
		end else if (c0 == CH_M && cnt7 > 7'd1 && c1 >= CH_0 && c1 <= CH_F) begin
			cls   = CLS_MEM;
			start = 1'b1;
		end else begin
			cls = CLS_UNKNOWN;
		end
	end

	always_comb begin
		act       = in_valid && in_ready && !halted_q;
		delim_c   = is_delim(char_in);
		proceed   = act && (in_comment_q ? (char_in == CH_NL) : (char_in != CH_SEMI));
		close_tok = proceed && delim_c && count_q != '0;
		ovf       = proceed && !delim_c && count_q >= CW'(StoreDepth);
		wr        = proceed && !delim_c && !ovf;
		job_push  = close_tok || ovf;
		job_ctl.cls   = ovf ? CLS_INSTR : cls;
		job_ctl.start = ovf ? 1'b0 : start;
		job_ctl.ovf   = ovf;
		job_count = ovf ? '0 : count_q;
		job_data  = store_q;
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			last_char_q <= char_in;
			for (int i = 0; i < StoreDepth; i++) begin
				if (count_q == CW'(i))
					store_q[i] <= char_in;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			in_comment_q <= 1'b0;
			halted_q     <= 1'b0;
		end else begin
			if (act) begin
				if (in_comment_q && char_in == CH_NL)
					in_comment_q <= 1'b0;
				else if (!in_comment_q && char_in == CH_SEMI)
					in_comment_q <= 1'b1;
			end
			if (close_tok)
				count_q <= '0;
			else if (wr)
				count_q <= count_q + CW'(1);
			if (ovf)
				halted_q <= 1'b1;
		end
	end

endmodule

// ===== rtl/atl_back.sv =====
// ----------------------------------------------------------------------------
// atl_back
// Emitter: pops a token job and sends its value one character per word
// through an output register.
// ----------------------------------------------------------------------------
module atl_back #(
	parameter int StoreDepth = 15,
	parameter int CW = 4
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     job_avail,
	output logic                     job_pop,
	input  atl_pkg::job_ctl_t        job_ctl,
	input  logic [CW-1:0]            job_count,
	input  logic [StoreDepth*8-1:0]  job_data,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [2:0]               token_class,
	output logic [7:0]               text_char,
	output logic                     char_valid,
	output logic                     last,
	output logic                     overflow_error
);
	import atl_pkg::*;

	logic                    busy_q;
	logic [StoreDepth*8-1:0] data_q;
	logic [CW-1:0]           rem_q;
	tok_class_t              cls_q;
	logic                    ovf_q;
	logic                    out_valid_q;
	logic                    emit;

	assign job_pop   = job_avail && !busy_q;
	assign emit      = busy_q && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk) begin
		if (job_pop) begin
			data_q <= job_ctl.start ? (job_data >> 8) : job_data;
			rem_q  <= job_count - CW'(job_ctl.start);
			cls_q  <= job_ctl.cls;
			ovf_q  <= job_ctl.ovf;
		end else if (emit) begin
			data_q <= data_q >> 8;
			rem_q  <= (rem_q == '0) ? '0 : rem_q - CW'(1);
		end
		if (emit) begin
			token_class    <= 3'(cls_q);
			text_char      <= (rem_q != '0) ? data_q[7:0] : 8'h00;
			char_valid     <= (rem_q != '0) && !ovf_q;
			last           <= (rem_q <= CW'(1));
			overflow_error <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (job_pop)
				busy_q <= 1'b1;
			else if (emit && rem_q <= CW'(1))
				busy_q <= 1'b0;
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== rtl/assembly_token_lexer.sv =====
// ----------------------------------------------------------------------------
// assembly_token_lexer
// Byte-stream assembly lexer: classifies tokens and streams their values.
//
// Input: one source byte per word on char_in (in_valid/in_ready). Output:
// one word per character of a closed token's value (out_valid/out_ready),
// with token_class, char_valid, last and overflow_error alongside.
// A closed token passes through the job queue and the emitter's job
// registers into the output register; words follow one per cycle while taken.
// Throughput: one input byte per cycle while the two-entry job queue has
// room; the emitter pops each job before sending its words,
// so bursts of short tokens stall the input when the queue fills.
// A stalled receiver holds the output register; the emitter then stops and
// the queue fills, after which in_ready drops.
// Reset clears the count, comment and halt flags, the queue, busy and out_valid.
// After a token's BUFFER_SIZE-th character one overflow word is sent and
// input is then taken and dropped until reset.
// ----------------------------------------------------------------------------
module assembly_token_lexer #(
	parameter int BUFFER_SIZE = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_in,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] token_class,
	output logic [7:0] text_char,
	output logic       char_valid,
	output logic       last,
	output logic       overflow_error
);
	import atl_pkg::*;

	localparam int StoreDepth = BUFFER_SIZE - 1;
	localparam int CW         = $clog2(BUFFER_SIZE);
	localparam int DW         = StoreDepth * 8;
	localparam int QW         = JOB_CTL_W + CW + DW;

	logic              push, full, pop, avail;
	job_ctl_t          f_ctl, b_ctl;
	logic [CW-1:0]     f_count, b_count;
	logic [DW-1:0]     f_data, b_data;
	logic [QW-1:0]     q_rdata;

	atl_front #(.StoreDepth(StoreDepth), .CW(CW)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .char_in(char_in),
		.job_push(push), .job_full(full),
		.job_ctl(f_ctl), .job_count(f_count), .job_data(f_data)
	);

	atl_fifo #(.W(QW)) u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(push), .wdata({f_ctl, f_count, f_data}), .full(full),
		.pop(pop), .not_empty(avail), .rdata(q_rdata)
	);

	assign {b_ctl, b_count, b_data} = q_rdata;

	atl_back #(.StoreDepth(StoreDepth), .CW(CW)) u_back (
		.clk(clk), .arst_n(arst_n),
		.job_avail(avail), .job_pop(pop),
		.job_ctl(b_ctl), .job_count(b_count), .job_data(b_data),
		.out_valid(out_valid), .out_ready(out_ready),
		.token_class(token_class), .text_char(text_char),
		.char_valid(char_valid), .last(last), .overflow_error(overflow_error)
	);

	a_ovf_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow_error |-> last && !char_valid)
		else $error("overflow word malformed");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !char_valid |-> text_char == 8'h00 && last)
		else $error("empty value word malformed");

	a_halt_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && overflow_error |=> !out_valid)
		else $error("output after overflow");

endmodule
